// ===== sv/jnorm_pkg.sv =====
// Shared types and constants for the joystick axis normalizer.
// Holds the request structs, the register map and the divider status struct.
// No dependencies.
`default_nettype none

package jnorm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 12;
  localparam int CENTER_W  = 12;
  localparam int DB_W      = 11;
  localparam int FS_W      = 12;
  localparam int POS_W     = 16;
  localparam int LOW_W     = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // Signed working width for center offsets and span
  localparam int OFS_W = SAMPLE_W + 1;

  // Divider: one quotient bit per step, Q1.15 result needs 16 bits
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;
  localparam int REM_W     = SAMPLE_W + 1;

  // Reset values and limits
  localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd2048;
  localparam logic [DB_W-1:0]     DB_RESET     = 11'd0;
  localparam logic [FS_W-1:0]     FS_RESET     = 12'd2047;
  localparam logic [LOW_W-1:0]    NO_MINIMUM   = 16'hFFFF;
  localparam logic [POS_W-1:0]    POS_MAX      = 16'h7FFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_V = 2'd0,
    CFG_CENTER_H = 2'd1,
    CFG_DEADBAND = 2'd2,
    CFG_FULL_SCALE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                axis;
    logic [SAMPLE_W-1:0] sample;
  } jnorm_in_t;

  typedef struct packed {
    logic                axis_out;
    logic [POS_W-1:0]    position;
    logic [LOW_W-1:0]    lowest_seen;
    logic [SAMPLE_W-1:0] highest_seen;
    logic                span_error;
  } jnorm_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== sv/jnorm_extremes.sv =====
// Per-axis lowest and highest sample tracker.
// Updates on a strobe and holds the values reported for the current sample.
// Depends on jnorm_pkg.
`default_nettype none

module jnorm_extremes #(
  parameter int AXIS_COUNT = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          update,
  input  wire logic                          axis,
  input  wire logic [jnorm_pkg::SAMPLE_W-1:0] sample,
  output logic [jnorm_pkg::LOW_W-1:0]        lowest,
  output logic [jnorm_pkg::SAMPLE_W-1:0]     highest
);
  import jnorm_pkg::*;

  // The axis field is one bit wide, so at most two slots are reachable
  localparam int SLOTS = (AXIS_COUNT > 2) ? 2 : AXIS_COUNT;

  logic [SAMPLE_W-1:0] min_val [SLOTS];
  logic [SLOTS-1:0]    min_seen;
  logic [SAMPLE_W-1:0] max_val [SLOTS];
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;

  // New extremes including the current sample
  always_comb begin
    if (!min_seen[axis] || (sample < min_val[axis])) begin
      min_next = sample;
    end else begin
      min_next = min_val[axis];
    end
    if (sample > max_val[axis]) begin
      max_next = sample;
    end else begin
      max_next = max_val[axis];
    end
  end

  // Store extremes and hold the reported pair
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        max_val[i] <= '0;
      end
    end else if (update) begin
      min_seen[axis] <= 1'b1;
      min_val[axis]  <= min_next;
      max_val[axis]  <= max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      lowest  <= LOW_W'(min_next);
      highest <= max_next;
    end
  end

  // A tracked axis never reports a minimum above its maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    $past(update) && !$past(rst) |-> lowest <= LOW_W'(highest))
    else $error("lowest above highest after update");

  // Reset empties every slot
  a_reset_clears: assert property (@(posedge clk)
    rst |=> min_seen == '0)
    else $error("minimum slots not cleared by reset");

  // An update marks its slot as seen
  a_update_seen: assert property (@(posedge clk) disable iff (rst)
    update |=> min_seen[$past(axis)])
    else $error("slot not marked after update");

endmodule

`default_nettype wire

// ===== sv/jnorm_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Computes (mag * 32768) / span for mag <= span, giving a 16-bit quotient.
// Depends on jnorm_pkg.
`default_nettype none

module jnorm_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [jnorm_pkg::SAMPLE_W-1:0] mag,
  input  wire logic [jnorm_pkg::SAMPLE_W-1:0] span,
  output logic [jnorm_pkg::POS_W-1:0]        quotient,
  output jnorm_pkg::div_status_t             status
);
  import jnorm_pkg::*;

  logic [REM_W-1:0]     rem;
  logic [SAMPLE_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 fits;
  logic [REM_W-1:0]     diff;
  logic [REM_W-1:0]     rem_next;

  // Trial subtract, keep on success, then shift for the next bit
  always_comb begin
    fits     = rem >= {1'b0, divisor};
    diff     = rem - {1'b0, divisor};
    rem_next = fits ? {diff[REM_W-2:0], 1'b0} : {rem[REM_W-2:0], 1'b0};
  end

  // Control: busy while stepping through DIV_STEPS quotient bits, then a one-cycle done
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else if (start) begin
      status.busy <= 1'b1;
      status.done <= 1'b0;
      cnt         <= '0;
    end else if (status.busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end else begin
      status.done <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, mag};
      divisor  <= span;
      quotient <= '0;
    end else if (status.busy) begin
      rem      <= rem_next;
      quotient <= {quotient[POS_W-2:0], fits};
    end
  end

  // Start leads to a busy unit
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> status.busy)
    else $error("divider not busy after start");

  // Busy and done never overlap
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    !(status.busy && status.done))
    else $error("divider busy and done together");

  // After the first step the remainder stays below twice the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    status.busy && cnt != '0 |-> rem < {divisor, 1'b0})
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== sv/joystick_axis_normalizer.sv =====
// Joystick axis normalizer: one request per converter sample gives one result with a
// signed Q1.15 position, the lowest and highest samples seen on that axis, and a span
// error flag. Only one request is in flight: the input takes no new request until the
// previous one has loaded the output register. A request passes through capture, the
// offset and clamp states, the 16-step shared restoring divider and the output load,
// which waits while a held result is not taken. When full scale does not exceed the
// deadband the divider is skipped. The output register holds a finished result until
// taken, while the next request is already accepted. The user must write configuration
// through a plain write port while the block is idle; the block does not enforce this.
// Depends on jnorm_pkg, jnorm_extremes and jnorm_divider.
`default_nettype none

module joystick_axis_normalizer #(
  parameter int AXIS_COUNT = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire jnorm_pkg::jnorm_in_t           in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output jnorm_pkg::jnorm_out_t               out_data,
  input  wire logic                           cfg_write,
  input  wire logic [jnorm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jnorm_pkg::CFG_W-1:0]    cfg_data
);
  import jnorm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_OFFSET = 5'b00010,
    ST_CLAMP  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [CENTER_W-1:0] center_vertical;
  logic [CENTER_W-1:0] center_horizontal;
  logic [DB_W-1:0]     deadband;
  logic [FS_W-1:0]     full_scale;

  // Request hold registers
  logic                axis_in;
  logic                axis_sel;
  logic [SAMPLE_W-1:0] sample;

  // Offset stage
  logic signed [OFS_W-1:0] center_s;
  logic signed [OFS_W-1:0] db_s;
  logic signed [OFS_W-1:0] ofs;
  logic signed [OFS_W-1:0] ofs_db_next;
  logic signed [OFS_W-1:0] ofs_db;
  logic signed [OFS_W-1:0] span_next;
  logic signed [OFS_W-1:0] span;
  logic                    span_error;

  // Clamp stage
  logic [SAMPLE_W-1:0] mag_next;
  logic [SAMPLE_W-1:0] mag;
  logic                neg;
  logic                div_start;

  // Divider and extremes
  logic [POS_W-1:0]    quotient;
  div_status_t         div_status;
  logic [LOW_W-1:0]    lowest;
  logic [SAMPLE_W-1:0] highest;
  logic [POS_W-1:0]    position;
  logic                load_out;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_vertical   <= CENTER_RESET;
      center_horizontal <= CENTER_RESET;
      deadband          <= DB_RESET;
      full_scale        <= FS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_V:   center_vertical   <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_H:   center_horizontal <= cfg_data[CENTER_W-1:0];
        CFG_DEADBAND:   deadband          <= cfg_data[DB_W-1:0];
        CFG_FULL_SCALE: full_scale        <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_OFFSET;
      ST_OFFSET: state_next = ST_CLAMP;
      ST_CLAMP:  state_next = span_error ? ST_WRITE : ST_DIVIDE;
      ST_DIVIDE: if (div_status.done) state_next = ST_WRITE;
      ST_WRITE:  if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Capture the request; axes past the configured count fall back to axis 0
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      axis_in  <= in_data.axis;
      axis_sel <= (AXIS_COUNT > 1) ? in_data.axis : 1'b0;
      sample   <= in_data.sample;
    end
  end

  // Subtract sample from center, remove deadband, form span
  always_comb begin
    center_s  = $signed({1'b0, (axis_sel ? center_horizontal : center_vertical)});
    db_s      = $signed({2'b00, deadband});
    ofs       = center_s - $signed({1'b0, sample});
    span_next = $signed({1'b0, full_scale}) - db_s;
    if (ofs > db_s) begin
      ofs_db_next = ofs - db_s;
    end else if (ofs < -db_s) begin
      ofs_db_next = ofs + db_s;
    end else begin
      ofs_db_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OFFSET) begin
      ofs_db     <= ofs_db_next;
      span       <= span_next;
      span_error <= (span_next <= 0);
    end
  end

  // Clamp to plus or minus span and take the magnitude
  always_comb begin
    if ((ofs_db > span) || (ofs_db < -span)) begin
      mag_next = span[SAMPLE_W-1:0];
    end else if (ofs_db < 0) begin
      mag_next = SAMPLE_W'(-ofs_db);
    end else begin
      mag_next = ofs_db[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLAMP) begin
      neg <= ofs_db < 0;
    end
  end

  assign mag       = mag_next;
  assign div_start = (state == ST_CLAMP) && !span_error;

  jnorm_extremes #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_extremes (
    .clk     (clk),
    .rst     (rst),
    .update  (state == ST_OFFSET),
    .axis    (axis_sel),
    .sample  (sample),
    .lowest  (lowest),
    .highest (highest)
  );

  jnorm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (mag),
    .span     (span[SAMPLE_W-1:0]),
    .quotient (quotient),
    .status   (div_status)
  );

  // Sign and saturate the quotient
  always_comb begin
    if (span_error) begin
      position = '0;
    end else if (neg) begin
      position = -quotient;
    end else if (quotient[POS_W-1]) begin
      position = POS_MAX;
    end else begin
      position = quotient;
    end
  end

  // Output register: load when empty or being drained
  assign load_out = (state == ST_WRITE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.axis_out     <= axis_in;
      out_data.position     <= position;
      out_data.lowest_seen  <= lowest;
      out_data.highest_seen <= highest;
      out_data.span_error   <= span_error;
    end
  end

  // One request at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A span error result carries a zero position
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.span_error |-> out_data.position == '0)
    else $error("span error with nonzero position");

  // The divider is running whenever the sequencer waits on it
  a_divide_active: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> div_status.busy || div_status.done)
    else $error("waiting on an idle divider");

  // The divider is only started with a positive span
  a_start_span: assert property (@(posedge clk) disable iff (rst)
    div_start |-> span > 0)
    else $error("divider started with non-positive span");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for joystick_axis_normalizer: drives sample requests and register writes,
// predicts every result and checks it field by field as it leaves the block.
// Depends on jnorm_pkg and the joystick_axis_normalizer RTL.
`timescale 1ns / 1ps

module tb;
  import jnorm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 75;
  localparam int CALM_PHASE    = 4;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cfg_reg_t         reg_sel;
    logic [CFG_W-1:0] value;
    jnorm_in_t        req;
    bit               typed;
    jnorm_out_t       result;
  } table_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  jnorm_in_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  jnorm_out_t           out_data;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  joystick_axis_normalizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copies of the registers and the per-axis extremes
  logic [CENTER_W-1:0] shadow_center [2];
  logic [DB_W-1:0]     shadow_deadband;
  logic [FS_W-1:0]     shadow_full_scale;
  logic [LOW_W-1:0]    shadow_lowest [2];
  logic [SAMPLE_W-1:0] shadow_highest [2];

  jnorm_out_t  awaited_results [$];
  table_row_t  directed_rows [$];
  jnorm_out_t  head_result;
  int          errors;
  int          requests_sent;
  int          results_checked;
  int          span_flags_seen;
  int          settings_used;
  int          hold_left;
  bit          idle_on;
  bit          hold_req;
  longint      cycles;

  // Update the extremes and compute the normalized position of one sample
  function automatic jnorm_out_t normalize_sample(input jnorm_in_t req);
    int         center;
    int         band;
    int         span;
    int         ofs;
    int         mag;
    int         quo;
    logic       ax;
    jnorm_out_t res;
    ax = req.axis;
    if (req.sample > shadow_highest[ax]) shadow_highest[ax] = req.sample;
    if (LOW_W'(req.sample) < shadow_lowest[ax]) shadow_lowest[ax] = LOW_W'(req.sample);
    center = int'(shadow_center[ax]);
    band   = int'(shadow_deadband);
    span   = int'(shadow_full_scale) - band;
    ofs    = center - int'(req.sample);
    // remove the dead zone around center
    if (ofs > band) ofs = ofs - band;
    else if (ofs < -band) ofs = ofs + band;
    else ofs = 0;
    res.axis_out     = req.axis;
    res.lowest_seen  = shadow_lowest[ax];
    res.highest_seen = shadow_highest[ax];
    res.span_error   = (span <= 0);
    res.position     = '0;
    if (span > 0) begin
      if (ofs > span) ofs = span;
      else if (ofs < -span) ofs = -span;
      mag = (ofs < 0) ? -ofs : ofs;
      quo = (mag * 32768) / span;
      if (ofs < 0) res.position = POS_W'(-quo);
      else res.position = (quo > 32767) ? POS_MAX : POS_W'(quo);
    end
    return res;
  endfunction

  // Pick a sample: mostly around the active region, some at edges, some anywhere
  function automatic jnorm_in_t random_request();
    jnorm_in_t req;
    int        c;
    int        s;
    int        fs;
    int        band;
    int        pick;
    req.axis = 1'($urandom_range(1));
    c    = int'(shadow_center[req.axis]);
    fs   = int'(shadow_full_scale);
    band = int'(shadow_deadband);
    pick = $urandom_range(99);
    if (pick < 20) begin
      s = $urandom_range(SAMPLE_TOP);
    end else if (pick < 40) begin
      case ($urandom_range(8))
        0: s = 0;
        1: s = SAMPLE_TOP;
        2: s = c;
        3: s = c + band;
        4: s = c - band;
        5: s = c + band + 1;
        6: s = c - band - 1;
        7: s = c + fs;
        default: s = c - fs;
      endcase
    end else begin
      s = c + $urandom_range(2 * fs + 16) - fs - 8;
    end
    if (s < 0) s = 0;
    if (s > SAMPLE_TOP) s = SAMPLE_TOP;
    req.sample = SAMPLE_W'(s);
    return req;
  endfunction

  task automatic add_write(input cfg_reg_t r, input int v);
    table_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_sel = r;
    row.value   = CFG_W'(v);
    row.req     = '0;
    row.typed   = 1'b0;
    row.result  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_request(input bit axis, input int sample);
    table_row_t row;
    row.kind       = ROW_REQUEST;
    row.reg_sel    = CFG_CENTER_V;
    row.value      = '0;
    row.req.axis   = axis;
    row.req.sample = SAMPLE_W'(sample);
    row.typed      = 1'b0;
    row.result     = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input bit axis, input int sample, input int pos,
                           input int low, input int high, input bit err);
    table_row_t row;
    row.kind                = ROW_REQUEST;
    row.reg_sel             = CFG_CENTER_V;
    row.value               = '0;
    row.req.axis            = axis;
    row.req.sample          = SAMPLE_W'(sample);
    row.typed               = 1'b1;
    row.result.axis_out     = axis;
    row.result.position     = POS_W'(pos);
    row.result.lowest_seen  = LOW_W'(low);
    row.result.highest_seen = SAMPLE_W'(high);
    row.result.span_error   = err;
    directed_rows.push_back(row);
  endtask

  // Write one register and mirror it, then drop the write strobe before returning
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_index <= r;
    cfg_data  <= v;
    cfg_write <= 1'b1;
    case (r)
      CFG_CENTER_V:   shadow_center[0]  = v;
      CFG_CENTER_H:   shadow_center[1]  = v;
      CFG_DEADBAND:   shadow_deadband   = v[DB_W-1:0];
      CFG_FULL_SCALE: shadow_full_scale = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_settings(input int cv, input int ch, input int band, input int fs);
    write_reg(CFG_CENTER_V, CFG_W'(cv));
    write_reg(CFG_CENTER_H, CFG_W'(ch));
    write_reg(CFG_DEADBAND, CFG_W'(band));
    write_reg(CFG_FULL_SCALE, CFG_W'(fs));
    settings_used++;
  endtask

  // Drop valid and wait until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_request(input jnorm_in_t req, input bit typed,
                              input jnorm_out_t typed_result);
    jnorm_out_t predicted;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = normalize_sample(req);
    awaited_results.push_back(typed ? typed_result : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("joystick_axis_normalizer test failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 30);
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: axis_out %0d position %0d", out_data.axis_out,
               $signed(out_data.position));
        errors++;
      end else begin
        head_result = awaited_results.pop_front();
        results_checked++;
        if (out_data.span_error === 1'b1) span_flags_seen++;
        if (out_data.axis_out !== head_result.axis_out) begin
          $error("axis_out: expected %0d, got %0d", head_result.axis_out, out_data.axis_out);
          errors++;
        end
        if (out_data.position !== head_result.position) begin
          $error("position: expected %0d, got %0d", $signed(head_result.position),
                 $signed(out_data.position));
          errors++;
        end
        if (out_data.lowest_seen !== head_result.lowest_seen) begin
          $error("lowest_seen: expected %0d, got %0d", head_result.lowest_seen,
                 out_data.lowest_seen);
          errors++;
        end
        if (out_data.highest_seen !== head_result.highest_seen) begin
          $error("highest_seen: expected %0d, got %0d", head_result.highest_seen,
                 out_data.highest_seen);
          errors++;
        end
        if (out_data.span_error !== head_result.span_error) begin
          $error("span_error: expected %0d, got %0d", head_result.span_error,
                 out_data.span_error);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    errors    = 0;
    cycles    = 0;
    shadow_center[0]  = CENTER_RESET;
    shadow_center[1]  = CENTER_RESET;
    shadow_deadband   = DB_RESET;
    shadow_full_scale = FS_RESET;
    for (int a = 0; a < 2; a++) begin
      shadow_lowest[a]  = NO_MINIMUM;
      shadow_highest[a] = '0;
    end

    // Directed table: reset settings, deadband edges, span error, extreme ranges
    add_typed(0, 0, 32767, 0, 0, 0);
    add_typed(0, 4095, -32768, 0, 4095, 0);
    add_typed(1, 2048, 0, 2048, 2048, 0);
    add_request(1, 2047);
    add_typed(1, 4095, -32768, 2047, 4095, 0);
    add_request(1, 1);
    add_write(CFG_DEADBAND, 100);
    add_write(CFG_FULL_SCALE, 1100);
    add_write(CFG_CENTER_V, 1000);
    add_write(CFG_CENTER_H, 3000);
    add_request(0, 1000);
    add_request(0, 1100);
    add_request(0, 1101);
    add_request(0, 899);
    add_request(0, 0);
    add_request(1, 4095);
    add_write(CFG_DEADBAND, 2047);
    add_write(CFG_FULL_SCALE, 2047);
    add_typed(0, 4095, 0, 0, 4095, 1);
    add_write(CFG_DEADBAND, 0);
    add_write(CFG_FULL_SCALE, 4095);
    add_write(CFG_CENTER_V, 0);
    add_write(CFG_CENTER_H, 4095);
    add_request(0, 4095);
    add_request(1, 0);
    add_request(0, 0);
    add_write(CFG_FULL_SCALE, 1);
    add_request(1, 4094);
    add_request(1, 4095);
    add_write(CFG_DEADBAND, 5);
    add_write(CFG_FULL_SCALE, 5);
    add_request(1, 2000);
    // deadband written with its unused top bit set
    add_write(CFG_DEADBAND, 4095);
    add_write(CFG_FULL_SCALE, 4095);
    add_request(0, 4095);
    add_request(0, 3000);

    // Hold reset, then release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // Random phases, each under its own register settings
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      int band;
      wait_idle();
      case (phase)
        0: write_settings(CENTER_RESET, CENTER_RESET, DB_RESET, FS_RESET);
        1: write_settings(0, SAMPLE_TOP, 0, 4095);
        2: begin
          band = $urandom_range(2047);
          write_settings($urandom_range(4095), $urandom_range(4095), band,
                         $urandom_range(band, 1));
        end
        3: begin
          band = $urandom_range(2047);
          write_settings($urandom_range(4095), $urandom_range(4095), band, band + 1);
        end
        CALM_PHASE: write_settings(SAMPLE_TOP, 0, 2047, 4095);
        default: write_settings($urandom_range(4095), $urandom_range(4095),
                                $urandom_range(4095), $urandom_range(4095, 1));
      endcase
      // Run one phase without idling and with the receiver held off
      idle_on = (phase != CALM_PHASE);
      if (phase == CALM_PHASE) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Sent %0d sample requests under %0d register settings plus a directed table.",
             requests_sent, settings_used);
    $display("Checked %0d results, %0d with the span flag, one %0d-cycle receiver hold-off.",
             results_checked, span_flags_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("joystick_axis_normalizer test passed");
    end else begin
      $display("joystick_axis_normalizer test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/jnorm_pkg.sv
sv/jnorm_extremes.sv
sv/jnorm_divider.sv
sv/joystick_axis_normalizer.sv
dv/tb.sv
